// ----- rtl/core/rlcf_pkg.sv -----
// Shared types and constants for the RGB linear cross-fader.
package rlcf_pkg;

	localparam int FADE_STEPS_DEF = 1020;
	localparam int LEVEL_MAX_DEF  = 255;

	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic div_bit;
		logic tick;
	} lane_ctl_t;

endpackage

// ----- rtl/core/rgb_linear_cross_fader.sv -----
// Top level of the three-channel RGB linear cross-fader.
// A start item (tuser = 0) loads new red/green/blue targets; the three lanes
// then derive their step intervals, FADE_STEPS divided by the gap, with a
// restoring divider that yields one quotient bit per cycle; the block takes
// no new item until the divider has finished and the result is loaded into
// the output register. A tick item (tuser = 1) steps the levels when it is
// accepted; ST_EMIT then loads the output register, which lets the next
// item be accepted while a result still waits on m_tready. m_tlast is the
// done flag: set on the last tick of a fade and on every idle tick.
module rgb_linear_cross_fader #(
	parameter int FADE_STEPS = rlcf_pkg::FADE_STEPS_DEF,
	parameter int LEVEL_MAX  = rlcf_pkg::LEVEL_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // target_red[7:0], target_green[15:8], target_blue[23:16]
	input  logic        s_tuser,  // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // red_level[7:0], green_level[15:8], blue_level[23:16]
	output logic        m_tlast   // fade_done
);

	localparam int LW = $clog2(LEVEL_MAX + 1);
	localparam int XW = (LW > 8) ? LW : 8;
	localparam int RW = $clog2(FADE_STEPS + 1);
	localparam int CW = $clog2(RW);
	localparam logic [RW-1:0] STEPS = RW'(FADE_STEPS);

	rlcf_pkg::state_t    state_q, state_d;
	rlcf_pkg::lane_ctl_t ctl;
	logic [CW-1:0]       cnt_q;
	logic [RW-1:0]       idx_q;
	logic                fading_q;
	logic                done_q;
	logic                out_load;
	logic                in_acc;
	logic                out_free;
	logic [LW-1:0]       lvl [3];
	logic [XW-1:0]       lvl_w [3];

	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	for (genvar k = 0; k < 3; k++) begin : g_lane
		rlcf_lane #(
			.FADE_STEPS(FADE_STEPS),
			.LEVEL_MAX (LEVEL_MAX)
		) u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (ctl),
			.target(s_tdata[8*k +: 8]),
			.level (lvl[k])
		);
		assign lvl_w[k] = XW'(lvl[k]);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rlcf_pkg::ST_IDLE: begin
				if (in_acc)
					state_d = (s_tuser == rlcf_pkg::OP_START) ? rlcf_pkg::ST_DIV
					                                          : rlcf_pkg::ST_EMIT;
			end
			rlcf_pkg::ST_DIV: begin
				if (cnt_q == '0)
					state_d = rlcf_pkg::ST_EMIT;
			end
			rlcf_pkg::ST_EMIT: begin
				if (out_free)
					state_d = rlcf_pkg::ST_IDLE;
			end
			default: state_d = rlcf_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		out_load     = 1'b0;
		ctl.load     = 1'b0;
		ctl.div_step = 1'b0;
		ctl.div_bit  = STEPS[cnt_q];
		ctl.tick     = 1'b0;
		case (state_q)
			rlcf_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				ctl.load = s_tvalid && (s_tuser == rlcf_pkg::OP_START);
				ctl.tick = s_tvalid && (s_tuser == rlcf_pkg::OP_TICK) && fading_q;
			end
			rlcf_pkg::ST_DIV: begin
				ctl.div_step = 1'b1;
			end
			rlcf_pkg::ST_EMIT: begin
				out_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rlcf_pkg::ST_IDLE;
			cnt_q    <= '0;
			idx_q    <= '0;
			fading_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.div_step)
				cnt_q <= cnt_q - CW'(1);
			if (in_acc) begin
				if (s_tuser == rlcf_pkg::OP_START) begin
					cnt_q    <= CW'(RW - 1);
					idx_q    <= '0;
					fading_q <= 1'b1;
					done_q   <= 1'b0;
				end else if (fading_q) begin
					if (idx_q >= STEPS) begin
						fading_q <= 1'b0;
						idx_q    <= '0;
						done_q   <= 1'b1;
					end else begin
						idx_q  <= idx_q + RW'(1);
						done_q <= 1'b0;
					end
				end else begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata <= {lvl_w[2][7:0], lvl_w[1][7:0], lvl_w[0][7:0]};
			m_tlast <= done_q;
		end
	end

	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!fading_q |-> idx_q == '0)
		else $error("tick index not cleared while idle");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_tuser == rlcf_pkg::OP_START) |=>
			(fading_q && !done_q && state_q == rlcf_pkg::ST_DIV))
		else $error("start item did not arm the fade");

	a_lvl_max: assert property (@(posedge clk) disable iff (!arst_n)
		lvl[0] <= LW'(LEVEL_MAX) && lvl[1] <= LW'(LEVEL_MAX) && lvl[2] <= LW'(LEVEL_MAX))
		else $error("level above maximum");

	a_fade_len: assert property (@(posedge clk) disable iff (!arst_n)
		fading_q |-> idx_q <= STEPS)
		else $error("tick index beyond fade length");

endmodule

// ----- rtl/core/rlcf_lane.sv -----
// One color lane: rate divider, tick residue counter and saturating level.
module rlcf_lane #(
	parameter int FADE_STEPS = rlcf_pkg::FADE_STEPS_DEF,
	parameter int LEVEL_MAX  = rlcf_pkg::LEVEL_MAX_DEF,
	localparam int LW = $clog2(LEVEL_MAX + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rlcf_pkg::lane_ctl_t ctl,
	input  logic [7:0]          target,
	output logic [LW-1:0]       level
);

	localparam int XW = (LW > 8) ? LW : 8;
	localparam int RW = $clog2(FADE_STEPS + 1);

	logic [LW-1:0]      level_q;
	logic               dir_q;
	logic               zero_q;
	logic [XW-1:0]      dvsr_q;
	logic [XW-1:0]      rem_q;
	logic [RW-1:0]      quo_q;
	logic [RW-1:0]      res_q;

	logic signed [XW:0] gap;
	logic [XW-1:0]      gap_mag;
	logic [XW:0]        trial;
	logic               fits;
	logic [XW:0]        trial_sub;
	logic               rate_nz;
	logic [RW:0]        res_inc;

	always_comb begin
		gap       = $signed({1'b0, XW'(target)}) - $signed({1'b0, XW'(level_q)});
		gap_mag   = gap[XW] ? XW'(-gap) : gap[XW-1:0];
		trial     = {rem_q, ctl.div_bit};
		fits      = trial >= {1'b0, dvsr_q};
		trial_sub = trial - {1'b0, dvsr_q};
		rate_nz   = !zero_q && (quo_q != '0);
		res_inc   = {1'b0, res_q} + (RW + 1)'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			dir_q   <= 1'b0;
			zero_q  <= 1'b1;
			dvsr_q  <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			res_q   <= '0;
		end else if (ctl.load) begin
			dir_q  <= !gap[XW];
			zero_q <= (gap == '0);
			dvsr_q <= gap_mag;
			rem_q  <= '0;
			quo_q  <= '0;
			res_q  <= '0;
		end else if (ctl.div_step) begin
			rem_q <= fits ? trial_sub[XW-1:0] : trial[XW-1:0];
			quo_q <= {quo_q[RW-2:0], fits};
		end else if (ctl.tick && rate_nz) begin
			res_q <= (res_inc == {1'b0, quo_q}) ? '0 : res_inc[RW-1:0];
			if (res_q == '0) begin
				if (dir_q) begin
					if (level_q < LW'(LEVEL_MAX))
						level_q <= level_q + LW'(1);
				end else begin
					if (level_q != '0)
						level_q <= level_q - LW'(1);
				end
			end
		end
	end

	assign level = level_q;

endmodule
